/* design/sliding_window_event_counter_defines.svh */
// Assertion macros for the sliding window event counter.
// Used by sliding_window_event_counter.sv; expects clk and arst_n in scope.
`ifndef SLIDING_WINDOW_EVENT_COUNTER_DEFINES_SVH
`define SLIDING_WINDOW_EVENT_COUNTER_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define SWEC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger
`define SWEC_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

/* design/swec_pkg.sv */
// Shared types and constants for the sliding window event counter.
// No dependencies.
package swec_pkg;

	// ring size default, compare slack and window reset value
	localparam int unsigned RING_DEPTH_DEFAULT = 64;
	localparam int unsigned WINDOW_SLACK_US    = 1000;
	localparam logic [31:0] WINDOW_RESET       = 32'd1000000;

	// operation codes on func
	localparam logic FUNC_RECORD = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	// register map: index taken from paddr[2]
	localparam logic REG_WINDOW = 1'b0;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} swec_state_t;

endpackage

/* design/sliding_window_event_counter.sv */
// Sliding window event counter: timestamp ring in a synchronous memory.
// Depends on swec_pkg and sliding_window_event_counter_defines.svh.
//
// Usage:
//   Command channel: an item (func, timestamp) is taken at a clock edge
//   with start high and busy low. func = record writes the timestamp at
//   the head of the ring; it finishes in that cycle and gives no result.
//   func = query walks back from the newest entry, one memory read per
//   cycle, counting entries whose time difference to the query time is
//   within window_usec + 1000 us; stops at first miss or oldest entry.
//   Result: event_count is valid for one cycle while done is high.
//   Timing: an empty-ring query answers in the cycle after it is taken;
//   a query that visits entries keeps busy high while it walks, reading
//   them one at a time through the single read port of the ring memory,
//   and answers when the walk ends; no new command is taken meanwhile.
//   The receiver cannot stall; each result is shown exactly once.
//   Config: APB register window_usec at address 0, written while idle.
//   Reset: pointer and fill count clear, window_usec = 1000000. The ring
//   memory is not cleared; only written entries are ever read.
`include "sliding_window_event_counter_defines.svh"

module sliding_window_event_counter
	import swec_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [63:0] timestamp,
	// result channel
	output logic        done,
	output logic [6:0]  event_count,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

	swec_state_t state_q, state_d;

	logic [31:0]       window_q;
	logic [PTR_W-1:0]  wp_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  hits_q;
	logic [PTR_W-1:0]  rd_addr_q;
	logic [63:0]       now_q;
	logic [32:0]       limit_q;
	logic [63:0]       rd_data_q;
	logic              done_q;
	logic [6:0]        count_q;

	logic [63:0]       ring [RING_DEPTH];

	logic              cmd_beat;
	logic              rec_beat;
	logic              qry_beat;
	logic [PTR_W-1:0]  head_prev;
	logic [PTR_W-1:0]  rd_prev;
	logic [63:0]       diff;
	logic              walk_pass;
	logic              walk_more;
	logic              rd_en;
	logic [PTR_W-1:0]  rd_addr;
	logic              result_en;
	logic [CNT_W-1:0]  result_hits;
	logic [CNT_W+6:0]  result_ext;

	assign cmd_beat = start && !busy;
	assign rec_beat = cmd_beat && (func == FUNC_RECORD);
	assign qry_beat = cmd_beat && (func == FUNC_QUERY);

	// ring index steps with wrap
	assign head_prev = (wp_q == '0) ? PTR_LAST : wp_q - 1'b1;
	assign rd_prev   = (rd_addr_q == '0) ? PTR_LAST : rd_addr_q - 1'b1;

	// window compare on the entry read last cycle
	assign diff      = now_q - rd_data_q;
	assign walk_pass = diff <= {31'b0, limit_q};
	assign walk_more = walk_pass && (CNT_W'(hits_q + 1'b1) < fill_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (qry_beat && fill_q != '0) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (!walk_more) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory read control and result
	always_comb begin
		rd_en       = 1'b0;
		rd_addr     = head_prev;
		result_en   = 1'b0;
		result_hits = '0;
		unique case (state_q)
			ST_IDLE: begin
				rd_en     = qry_beat && fill_q != '0;
				result_en = qry_beat && fill_q == '0;
			end
			ST_WALK: begin
				rd_en       = walk_more;
				rd_addr     = rd_prev;
				result_en   = !walk_more;
				result_hits = walk_pass ? CNT_W'(hits_q + 1'b1) : hits_q;
			end
			default: ;
		endcase
	end

	// count reported modulo 128
	assign result_ext = {7'b0, result_hits};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wp_q     <= '0;
			fill_q   <= '0;
			hits_q   <= '0;
			done_q   <= 1'b0;
			window_q <= WINDOW_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= result_en;
			if (rec_beat) begin
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
				if (fill_q != CNT_FULL) fill_q <= fill_q + 1'b1;
			end
			if (qry_beat) hits_q <= '0;
			else if (state_q == ST_WALK && walk_more) hits_q <= CNT_W'(hits_q + 1'b1);
			if (psel && penable && pwrite && paddr[2] == REG_WINDOW) window_q <= pwdata;
		end
	end

	// query payload, read address and result registers
	always_ff @(posedge clk) begin
		if (qry_beat) begin
			now_q   <= timestamp;
			limit_q <= {1'b0, window_q} + 33'(WINDOW_SLACK_US);
		end
		if (rd_en) rd_addr_q <= rd_addr;
		if (result_en) count_q <= result_ext[6:0];
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (rec_beat) ring[wp_q] <= timestamp;
		if (rd_en) rd_data_q <= ring[rd_addr];
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign event_count = count_q;
	assign prdata      = (paddr[2] == REG_WINDOW) ? window_q : 32'd0;
	assign pready      = 1'b1;

	// checks
	`SWEC_ASSERT(a_fill_bound, fill_q <= CNT_FULL, "fill count beyond ring depth")
	`SWEC_ASSERT(a_walk_hits, state_q != ST_WALK || hits_q < fill_q, "walk past fill count")
	`SWEC_ASSERT_NEXT(a_empty_query, qry_beat && fill_q == '0, done && event_count == 7'd0,
		"empty ring query must answer zero next cycle")
	`SWEC_ASSERT_NEXT(a_walk_end, state_q == ST_WALK && !walk_more, done && !busy,
		"walk end must give one result")

endmodule
